/* src/mmgn_pkg.sv */
// Shared types and constants of the min/max gray normalizer.
`default_nettype none
package mmgn_pkg;

  localparam int MAX_PIXELS   = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_BITS    = $clog2(MAX_PIXELS);
  localparam int CNT_BITS     = $clog2(MAX_PIXELS + 1);
  localparam int DIM_BITS     = 13;
  localparam int DIM_LIMIT    = 4096;
  localparam int POS_BITS     = DIM_BITS - 1;
  localparam int SIZE_BITS    = 2 * DIM_BITS;
  localparam int GRAY_BITS    = 8;
  localparam int GRAY_FULL    = 255;
  localparam int PROD_BITS    = SAMPLE_BITS + GRAY_BITS;
  localparam int STEP_BITS    = $clog2(GRAY_BITS);
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DIV
  } state_t;

  typedef struct packed {
    cmd_t                          command;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [GRAY_BITS-1:0] gray;
    logic                 flat_frame;
    logic                 last_pixel;
  } out_word_t;

  typedef struct packed {
    logic                   start;
    logic [PROD_BITS-1:0]   num;
    logic [SAMPLE_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [GRAY_BITS-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/mmgn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mmgn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* src/mmgn_div.sv */
// Bit-serial restoring divider producing one gray quotient bit per cycle.
`default_nettype none
module mmgn_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mmgn_pkg::div_req_t req,
  output mmgn_pkg::div_rsp_t      rsp
);
  import mmgn_pkg::*;

  logic                 active_r, active_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic [PROD_BITS-1:0] rem_r, rem_nxt;
  logic [PROD_BITS-1:0] den_sh_r, den_sh_nxt;
  logic [GRAY_BITS-1:0] quot_r, quot_nxt;
  logic                 ge;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    den_sh_nxt = den_sh_r;
    quot_nxt   = quot_r;
    ge         = rem_r >= den_sh_r;
    if (req.start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      rem_nxt    = req.num;
      den_sh_nxt = PROD_BITS'(req.den) << (GRAY_BITS - 1);
      quot_nxt   = '0;
    end else if (active_r) begin
      if (ge) begin
        rem_nxt = rem_r - den_sh_r;
      end
      quot_nxt   = {quot_r[GRAY_BITS-2:0], ge};
      den_sh_nxt = den_sh_r >> 1;
      cnt_nxt    = cnt_r + STEP_BITS'(1);
      if (cnt_r == STEP_BITS'(GRAY_BITS - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r    <= rem_nxt;
    den_sh_r <= den_sh_nxt;
    quot_r   <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
`default_nettype wire

/* src/min_max_gray_normalizer_core.sv */
// Top level of the min/max gray normalizer: frame store, counters and read sequencer.
//
// Usage:
//   Input channel: a word is taken at a clock edge with start high and busy
//   low. A load word (command 0) writes the next sample into the frame store
//   in column-major order and updates the frame minimum and maximum; busy
//   stays low, so loads stream at one per cycle.
//   Once width*height samples are in, a read word (command 1) returns the next
//   pixel in row-major order. A read holds busy through the frame store read,
//   the bit-serial divider (one quotient bit per cycle) and its done flag;
//   out_strobe rises as busy drops.
//   Flat frames skip the divider: busy covers only the frame store read, and
//   out_strobe pulses in the cycle after it.
//   Reads before the frame is full, loads after it is full, and every word
//   while width*height exceeds the store are taken and dropped.
//   Result channel: out_word is valid for the single cycle out_strobe is high;
//   the receiver cannot stall.
//   Configuration: cfg_we writes cfg_data to register cfg_index; a write to
//   either register restarts the frame, writes to other indexes are dropped.
//   Reset restores 64x64 and an empty frame.
`default_nettype none
module min_max_gray_normalizer_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire mmgn_pkg::in_word_t                    in_word,
  output logic                                       out_strobe,
  output mmgn_pkg::out_word_t                        out_word,
  input  wire logic                                  cfg_we,
  input  wire logic [mmgn_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [mmgn_pkg::DIM_BITS-1:0]         cfg_data
);
  import mmgn_pkg::*;

  logic [DIM_BITS-1:0]           width_r, height_r;
  logic [DIM_BITS-1:0]           w_eff, h_eff, w_last, h_last;
  logic [SIZE_BITS-1:0]          frame_size;
  logic                          oversize, frame_full;
  logic                          accept, do_load, do_read, at_last;
  logic                          cfg_hit;

  logic [CNT_BITS-1:0]           load_count_r, load_count_nxt;
  logic [POS_BITS-1:0]           row_r, row_nxt, col_r, col_nxt;
  logic [ADDR_BITS-1:0]          rd_addr_r, rd_addr_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic                          last_r, last_nxt;

  state_t                        state_r, state_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  out_word_t                     out_word_r, out_word_nxt;

  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SAMPLE_BITS:0]   x_ext, min_ext, max_ext, num_ext, den_ext;
  logic [PROD_BITS-1:0]          prod;
  logic                          flat;
  div_req_t                      div_req;
  div_rsp_t                      div_rsp;

  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_BITS'(1);
    end else if (width_r > DIM_BITS'(DIM_LIMIT)) begin
      w_eff = DIM_BITS'(DIM_LIMIT);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_BITS'(1);
    end else if (height_r > DIM_BITS'(DIM_LIMIT)) begin
      h_eff = DIM_BITS'(DIM_LIMIT);
    end else begin
      h_eff = height_r;
    end
  end

  assign w_last     = w_eff - DIM_BITS'(1);
  assign h_last     = h_eff - DIM_BITS'(1);
  assign frame_size = SIZE_BITS'(w_eff) * SIZE_BITS'(h_eff);
  assign oversize   = frame_size > SIZE_BITS'(MAX_PIXELS);
  assign frame_full = SIZE_BITS'(load_count_r) >= frame_size;

  assign cfg_hit = cfg_we && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});

  assign busy    = state_r != S_IDLE;
  assign accept  = start && !busy;
  assign do_load = accept && (in_word.command == CMD_LOAD) && !oversize && !frame_full;
  assign do_read = accept && (in_word.command == CMD_READ) && !oversize && frame_full;
  assign at_last = (row_r == h_last[POS_BITS-1:0]) && (col_r == w_last[POS_BITS-1:0]);

  mmgn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_PIXELS)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (load_count_r[ADDR_BITS-1:0]),
    .wr_data (in_word.sample),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // frame counters and running extremes
  always_comb begin
    load_count_nxt = load_count_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    rd_addr_nxt    = rd_addr_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    last_nxt       = last_r;
    if (cfg_hit) begin
      load_count_nxt = '0;
      row_nxt        = '0;
      col_nxt        = '0;
      rd_addr_nxt    = '0;
    end else if (do_load) begin
      load_count_nxt = load_count_r + CNT_BITS'(1);
      if (load_count_r == '0) begin
        min_nxt = in_word.sample;
        max_nxt = in_word.sample;
      end else begin
        if (in_word.sample < min_r) begin
          min_nxt = in_word.sample;
        end
        if (in_word.sample > max_r) begin
          max_nxt = in_word.sample;
        end
      end
    end else if (do_read) begin
      last_nxt = at_last;
      if (at_last) begin
        load_count_nxt = '0;
        row_nxt        = '0;
        col_nxt        = '0;
        rd_addr_nxt    = '0;
      end else if (col_r == w_last[POS_BITS-1:0]) begin
        col_nxt     = '0;
        row_nxt     = row_r + POS_BITS'(1);
        rd_addr_nxt = ADDR_BITS'(row_r + POS_BITS'(1));
      end else begin
        col_nxt     = col_r + POS_BITS'(1);
        rd_addr_nxt = rd_addr_r + ADDR_BITS'(h_eff);
      end
    end
  end

  assign x_ext   = {rd_data[SAMPLE_BITS-1], rd_data};
  assign min_ext = {min_r[SAMPLE_BITS-1], min_r};
  assign max_ext = {max_r[SAMPLE_BITS-1], max_r};
  assign num_ext = x_ext - min_ext;
  assign den_ext = max_ext - min_ext;
  assign prod    = PROD_BITS'(num_ext[SAMPLE_BITS-1:0]) * PROD_BITS'(GRAY_FULL);
  assign flat    = min_r == max_r;

  // read sequencer
  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    div_req.start  = 1'b0;
    div_req.num    = prod;
    div_req.den    = den_ext[SAMPLE_BITS-1:0];
    case (state_r)
      S_IDLE: begin
        if (do_read) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (flat) begin
          out_strobe_nxt          = 1'b1;
          out_word_nxt.gray       = '0;
          out_word_nxt.flat_frame = 1'b1;
          out_word_nxt.last_pixel = last_r;
          state_nxt               = S_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          out_strobe_nxt          = 1'b1;
          out_word_nxt.gray       = div_rsp.quot;
          out_word_nxt.flat_frame = 1'b0;
          out_word_nxt.last_pixel = last_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  mmgn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= DIM_BITS'(64);
      height_r     <= DIM_BITS'(64);
      load_count_r <= '0;
      row_r        <= '0;
      col_r        <= '0;
      rd_addr_r    <= '0;
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_FRAME_WIDTH)) begin
        width_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_FRAME_HEIGHT)) begin
        height_r <= cfg_data;
      end
      load_count_r <= load_count_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      rd_addr_r    <= rd_addr_nxt;
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    last_r     <= last_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held for more than one cycle");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    do_read |=> busy)
    else $error("accepted read did not hold busy");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == S_FETCH || $past(state_r) == S_DIV))
    else $error("result strobe without a read in flight");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

endmodule
`default_nettype wire

/* tb/mmgn_stretch_checker.sv */
// Watches the normalizer's channels, predicts each gray word and compares it with the DUT.
module mmgn_stretch_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  mmgn_pkg::in_word_t                in_word,
  input  logic                              out_strobe,
  input  mmgn_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [mmgn_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mmgn_pkg::DIM_BITS-1:0]     cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import mmgn_pkg::*;

  logic signed [SAMPLE_BITS-1:0] pix_mem [MAX_PIXELS];
  logic signed [SAMPLE_BITS-1:0] lo_val;
  logic signed [SAMPLE_BITS-1:0] hi_val;
  logic [DIM_BITS-1:0]           width_reg;
  logic [DIM_BITS-1:0]           height_reg;
  int unsigned                   loaded;
  int unsigned                   row;
  int unsigned                   col;
  out_word_t                     gray_q[$];

  function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  task automatic restart_frame();
    loaded = 0;
    row    = 0;
    col    = 0;
  endtask

  task automatic stretch_word(input in_word_t word);
    int unsigned wd;
    int unsigned ht;
    int unsigned size;
    int          x;
    int          num;
    int          den;
    out_word_t   res;
    wd   = clamp_dim(width_reg);
    ht   = clamp_dim(height_reg);
    size = wd * ht;
    if (size > MAX_PIXELS) return;
    if (word.command == CMD_LOAD) begin
      if (loaded >= size) return;
      pix_mem[loaded] = word.sample;
      if (loaded == 0) begin
        lo_val = word.sample;
        hi_val = word.sample;
      end else begin
        if (word.sample < lo_val) lo_val = word.sample;
        if (word.sample > hi_val) hi_val = word.sample;
      end
      loaded++;
      return;
    end
    if (loaded < size) return;
    x = pix_mem[row + col * ht];
    res.last_pixel = (row == ht - 1) && (col == wd - 1);
    if (lo_val == hi_val) begin
      res.flat_frame = 1'b1;
      res.gray       = '0;
    end else begin
      num            = x - int'(lo_val);
      den            = int'(hi_val) - int'(lo_val);
      res.flat_frame = 1'b0;
      res.gray       = GRAY_BITS'((GRAY_FULL * num) / den);
    end
    gray_q.push_back(res);
    if (res.last_pixel) begin
      restart_frame();
    end else begin
      col++;
      if (col >= wd) begin
        col = 0;
        row++;
      end
    end
  endtask

  task automatic compare_word();
    out_word_t want;
    if (gray_q.size() == 0) begin
      $error("result word with nothing expected: gray %0d flat_frame %0d last_pixel %0d",
             out_word.gray, out_word.flat_frame, out_word.last_pixel);
      fail_count++;
      return;
    end
    want = gray_q.pop_front();
    if (out_word.gray !== want.gray) begin
      $error("gray: expected %0d, actual %0d", want.gray, out_word.gray);
      fail_count++;
    end
    if (out_word.flat_frame !== want.flat_frame) begin
      $error("flat_frame: expected %0d, actual %0d", want.flat_frame, out_word.flat_frame);
      fail_count++;
    end
    if (out_word.last_pixel !== want.last_pixel) begin
      $error("last_pixel: expected %0d, actual %0d", want.last_pixel, out_word.last_pixel);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = DIM_BITS'(64);
      height_reg = DIM_BITS'(64);
      lo_val     = '0;
      hi_val     = '0;
      restart_frame();
      gray_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data;
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
      end
      if (start && !busy) stretch_word(in_word);
      if (out_strobe) compare_word();
    end
    pending = gray_q.size();
  end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the min/max gray normalizer: frames, register changes and noise.
module tb_top;
  import mmgn_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_WORDS  = 850;
  localparam logic [CFG_IDX_BITS-1:0] SPARE_INDEX_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] SPARE_INDEX_HI = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  in_word_t                in_word = '0;
  logic                    out_strobe;
  out_word_t               out_word;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DIM_BITS-1:0]     cfg_data = '0;
  int                      fail_count;
  int                      pending;
  int unsigned             cycles = 0;
  int                      idle_pct = 31;
  int                      words_done = 0;
  int unsigned             width_raw = 64;
  int unsigned             height_raw = 64;

  min_max_gray_normalizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mmgn_stretch_checker stretch_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned dim_of(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > DIM_LIMIT) return DIM_LIMIT;
    return raw;
  endfunction

  task automatic put_word(cmd_t cmd, logic [SAMPLE_BITS-1:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= '{command: cmd, sample: sample};
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    @(negedge clk) start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DIM_BITS'(data);
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_raw = data % (1 << DIM_BITS);
    if (idx == REG_FRAME_HEIGHT) height_raw = data % (1 << DIM_BITS);
  endtask

  task automatic set_dims(int unsigned w, int unsigned h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // span 0 gives a flat frame; premature reads are mixed in at noise_pct
  task automatic load_frame(int n, int span, int noise_pct);
    int lo;
    lo = -32768 + $urandom_range(65535 - span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) put_word(CMD_READ, SAMPLE_BITS'($urandom));
      put_word(CMD_LOAD, SAMPLE_BITS'(lo + $urandom_range(span)));
      words_done++;
    end
  endtask

  task automatic read_frame(int n);
    for (int i = 0; i < n; i++) begin
      put_word(CMD_READ, SAMPLE_BITS'($urandom));
      words_done++;
    end
  endtask

  task automatic random_phase();
    int unsigned w;
    int unsigned h;
    int          n;
    int          span;
    int          pick;
    bit          cut;
    pick = $urandom_range(19);
    if (pick == 0) begin
      w = $urandom_range(1025, 8191);
      h = $urandom_range(5, 8);
    end else begin
      w = (pick == 1) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
    end
    if ($urandom_range(1)) set_dims(w, h);
    else begin
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_FRAME_WIDTH, w);
    end
    n = dim_of(width_raw) * dim_of(height_raw);
    if (n > MAX_PIXELS) begin
      repeat ($urandom_range(1, 6)) put_word(cmd_t'($urandom_range(1)), SAMPLE_BITS'($urandom));
      return;
    end
    cut = 1'b0;
    repeat ($urandom_range(1, 3)) begin
      if (cut) break;
      pick = $urandom_range(9);
      span = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(3) :
             (pick < 5) ? $urandom_range(255) : 65535;
      if ($urandom_range(19) == 0) begin
        load_frame($urandom_range(0, n - 1), span, 8);
        cut = 1'b1;
        break;
      end
      load_frame(n, span, 8);
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) put_word(CMD_LOAD, SAMPLE_BITS'($urandom));
      if ($urandom_range(7) == 0) settle();
      if ($urandom_range(9) == 0) begin
        read_frame($urandom_range(0, n - 1));
        cut = 1'b1;
        break;
      end
      read_frame(n);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    put_word(CMD_READ, SAMPLE_BITS'($urandom));
    set_dims(2, 2);
    put_word(CMD_LOAD, 16'sh8000);
    put_word(CMD_LOAD, 16'sh7fff);
    put_word(CMD_LOAD, 16'sh0000);
    put_word(CMD_READ, 16'sh1234);
    put_word(CMD_LOAD, 16'shffff);
    put_word(CMD_LOAD, 16'sh0005);
    read_frame(4);
    put_word(CMD_LOAD, 16'sd100);
    put_word(CMD_LOAD, 16'sd101);
    put_word(CMD_LOAD, 16'sd101);
    put_word(CMD_LOAD, 16'sd100);
    read_frame(4);
    set_dims(0, 0);
    put_word(CMD_LOAD, 16'sd7);
    read_frame(1);
    write_reg(REG_FRAME_HEIGHT, 2);
    put_word(CMD_LOAD, 16'sd3);
    write_reg(SPARE_INDEX_LO, 8191);
    write_reg(SPARE_INDEX_HI, 0);
    put_word(CMD_LOAD, 16'sd9);
    read_frame(2);
    set_dims(3, 1);
    repeat (3) put_word(CMD_LOAD, -16'sd4);
    read_frame(3);
    set_dims(8191, 2);
    put_word(CMD_LOAD, 16'sh5a5a);
    put_word(CMD_READ, 16'sha5a5);

    words_done = 0;
    while (words_done < RANDOM_WORDS) begin
      idle_pct = (words_done < RANDOM_WORDS / 3) ? 31 :
                 (words_done < 2 * RANDOM_WORDS / 3) ? 49 : 0;
      random_phase();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/mmgn_pkg.sv
src/mmgn_ram.sv
src/mmgn_div.sv
src/min_max_gray_normalizer_core.sv
tb/mmgn_stretch_checker.sv
tb/tb_top.sv
